/* src/ekvp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaped key/value parser package
// Word types, phase codes, status codes and the special bytes of the format.
// ----------------------------------------------------------------------------
package ekvp_pkg;

    typedef struct packed {
        logic       has_char;
        logic [7:0] ch;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] out_char;
        logic       in_value;
        logic       key_done;
        logic       pair_done;
        logic [1:0] status;
    } out_word_t;

    typedef enum logic [4:0] {
        PH_KEY     = 5'b00001,
        PH_KEY_ESC = 5'b00010,
        PH_VAL     = 5'b00100,
        PH_VAL_ESC = 5'b01000,
        PH_ERR     = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   key_seen;
    } ekvp_state_t;

    localparam logic [1:0] ST_BUSY    = 2'd0;
    localparam logic [1:0] ST_OK      = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam logic [7:0] BYTE_ESC = 8'h5C;
    localparam logic [7:0] BYTE_EQ  = 8'h3D;
    localparam logic [7:0] BYTE_SEP = 8'h3B;

endpackage : ekvp_pkg
`default_nettype wire

/* src/ekvp_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaped key/value parser step
// Decides one input word against the current phase: result word and next state.
// ----------------------------------------------------------------------------
module ekvp_step (
    input  var ekvp_pkg::ekvp_state_t state_cur,
    input  var ekvp_pkg::in_word_t    in_word,
    output ekvp_pkg::ekvp_state_t     state_nxt,
    output ekvp_pkg::out_word_t       out_word
);
    import ekvp_pkg::*;

    always_comb begin
        phase_t     ph;
        logic       ks;
        logic       err;
        logic       esc_ok;
        out_word_t  res;

        ph     = state_cur.phase;
        ks     = state_cur.key_seen;
        err    = 1'b0;
        esc_ok = (in_word.ch == BYTE_ESC) || (in_word.ch == BYTE_EQ)
                 || (in_word.ch == BYTE_SEP);
        res    = '0;
        res.status = ST_BUSY;

        case (state_cur.phase)
            PH_KEY, PH_KEY_ESC, PH_VAL, PH_VAL_ESC: begin
                if (in_word.has_char) begin
                    case (state_cur.phase)
                        PH_KEY: begin
                            if (in_word.ch == BYTE_ESC) begin
                                ph = PH_KEY_ESC;
                            end else if (in_word.ch == BYTE_EQ) begin
                                if (ks) begin
                                    res.key_done = 1'b1;
                                    ks = 1'b0;
                                    ph = PH_VAL;
                                end else begin
                                    err = 1'b1;
                                end
                            end else if (in_word.ch == BYTE_SEP) begin
                                err = 1'b1;
                            end else begin
                                res.char_valid = 1'b1;
                                res.out_char   = in_word.ch;
                                ks = 1'b1;
                            end
                        end
                        PH_KEY_ESC: begin
                            if (esc_ok) begin
                                res.char_valid = 1'b1;
                                res.out_char   = in_word.ch;
                                ks = 1'b1;
                                ph = PH_KEY;
                            end else begin
                                err = 1'b1;
                            end
                        end
                        PH_VAL: begin
                            if (in_word.ch == BYTE_ESC) begin
                                ph = PH_VAL_ESC;
                            end else if (in_word.ch == BYTE_EQ) begin
                                err = 1'b1;
                            end else if (in_word.ch == BYTE_SEP) begin
                                res.pair_done = 1'b1;
                                ph = PH_KEY;
                            end else begin
                                res.char_valid = 1'b1;
                                res.out_char   = in_word.ch;
                                res.in_value   = 1'b1;
                            end
                        end
                        PH_VAL_ESC: begin
                            if (esc_ok) begin
                                res.char_valid = 1'b1;
                                res.out_char   = in_word.ch;
                                res.in_value   = 1'b1;
                                ph = PH_VAL;
                            end else begin
                                err = 1'b1;
                            end
                        end
                        default: begin
                            err = 1'b1;
                        end
                    endcase
                end
                if (!err && in_word.last) begin
                    if (ph == PH_KEY) begin
                        if (ks) begin
                            err = 1'b1;
                        end else begin
                            res.status = ST_OK;
                        end
                    end else if (ph == PH_VAL) begin
                        res.pair_done = 1'b1;
                        res.status    = ST_OK;
                    end else begin
                        err = 1'b1;
                    end
                end
                if (err) begin
                    res        = '0;
                    res.status = ST_ERROR;
                    ph         = PH_ERR;
                end
            end
            default: begin
                res.status = ST_IGNORED;
            end
        endcase

        if (in_word.last) begin
            ph = PH_KEY;
            ks = 1'b0;
        end

        state_nxt.phase    = ph;
        state_nxt.key_seen = ks;
        out_word           = res;
    end

endmodule : ekvp_step
`default_nettype wire

/* src/escaped_key_value_parser_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escaped key/value parser unit
// Takes an encoded "key=value;" string one byte per word on the s_ channel and
// returns one result word per input word on the m_ channel: the unescaped
// character with its field, key and pair end marks, and a status code.
// Both channels use valid/ready; a word moves when valid and ready are high.
// Each accepted word enters an input register, is decided combinationally by
// the phase machine and lands in the result register, which drives m_valid.
// One word is accepted per cycle while m_ready holds.
// When the receiver stalls, the result register holds and the input register
// fills; s_ready then drops until the result is taken, so no word is lost.
// A word with last set returns the parser to the key phase for a new string.
// Reset (aresetn low, synchronous) empties both registers and restarts the
// parser in the key phase with an empty key.
// ----------------------------------------------------------------------------
module escaped_key_value_parser_unit (
    input  var logic                aclk,
    input  var logic                aresetn,
    input  var logic                s_valid,
    output logic                    s_ready,
    input  var ekvp_pkg::in_word_t  s_data,
    output logic                    m_valid,
    input  var logic                m_ready,
    output ekvp_pkg::out_word_t     m_data
);
    import ekvp_pkg::*;

    logic        in_valid_reg;
    in_word_t    in_word_reg;
    logic        out_valid_reg;
    out_word_t   out_word_reg;
    ekvp_state_t state_reg;
    ekvp_state_t state_next;
    out_word_t   res_next;
    logic        out_adv;
    logic        in_adv;

    assign out_adv = !out_valid_reg || m_ready;
    assign in_adv  = in_valid_reg && out_adv;
    assign s_ready = !in_valid_reg || out_adv;
    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    ekvp_step u_step (
        .state_cur (state_reg),
        .in_word   (in_word_reg),
        .state_nxt (state_next),
        .out_word  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            state_reg.phase    <= PH_KEY;
            state_reg.key_seen <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_adv) begin
                out_valid_reg <= in_valid_reg;
            end
            if (in_adv) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_data;
        end
        if (in_adv) begin
            out_word_reg <= res_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg.phase))
        else $error("phase register not one-hot");

    a_last_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_adv && in_word_reg.last) |=>
            (state_reg.phase == PH_KEY && !state_reg.key_seen))
        else $error("parser did not restart after last word");

    a_error_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_adv && !in_word_reg.last && res_next.status == ST_ERROR) |=>
            (state_reg.phase == PH_ERR))
        else $error("error not held for rest of string");

    a_quiet_on_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_word_reg.status == ST_ERROR ||
                           out_word_reg.status == ST_IGNORED)) |->
            (!out_word_reg.char_valid && !out_word_reg.key_done &&
             !out_word_reg.pair_done && out_word_reg.out_char == 8'd0))
        else $error("fields set on error or ignored word");

    a_no_loss_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(out_word_reg)))
        else $error("result word dropped while stalled");
`endif

endmodule : escaped_key_value_parser_unit
`default_nettype wire
